// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BATS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BATS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bats_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bats_pkg;

    localparam int PE_COUNT    = 32;
    localparam int INDEX_BITS  = 24;
    localparam int LEN_BITS    = 24;
    localparam int IN_ROW_BITS = 64;
    localparam int ROW_BITS    = 2 * PE_COUNT;
    localparam int POS_BITS    = $clog2(ROW_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [IN_ROW_BITS-1:0] PAIRS_V = {(IN_ROW_BITS/2){2'b01}};
    localparam logic [IN_ROW_BITS-1:0] PAIRS_H = {(IN_ROW_BITS/2){2'b10}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_A = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_B = 1'b1;

    localparam logic [1:0] ARW_ZERO = 2'd0;
    localparam logic [1:0] ARW_UP   = 2'd1;
    localparam logic [1:0] ARW_LEFT = 2'd2;
    localparam logic [1:0] ARW_DIAG = 2'd3;

    // position offset, 3-bit two's complement
    localparam logic [2:0] OFF_ZERO   = 3'b000;
    localparam logic [2:0] OFF_PLUS2  = 3'b010;
    localparam logic [2:0] OFF_MINUS2 = 3'b110;

    typedef enum logic [1:0] {
        FN_DIR   = 2'd0,
        FN_FIRST = 2'd1,
        FN_NEXT  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_V       = 2'd1,
        DIR_H       = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BADDIR = 3'd1,
        ST_NONE   = 3'd2,
        ST_MANY   = 3'd3,
        ST_OUT    = 3'd4,
        ST_ZERO   = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]             func;
        logic [IN_ROW_BITS-1:0] row_bits;
    } t_in;

    typedef struct packed {
        logic [2:0]          status;
        logic                step_valid;
        logic                gap_a;
        logic                gap_b;
        logic [LEN_BITS-1:0] index_a;
        logic [LEN_BITS-1:0] index_b;
        logic [1:0]          arrow_used;
        logic [1:0]          rows_back;
        logic                done_res;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        t_func                func;
        t_status              stat;
        t_dir                 dir;
        logic [1:0]           raw;
        logic [POS_BITS-1:0]  pos;
        logic [ROW_BITS-1:0]  row;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/banded_alignment_traceback_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Banded traceback step: every accepted request gives exactly one result.
// Sustained rate is one request per cycle while the output side takes results;
// each accepted request passes the command queue, then its result is held in
// the output register. The rate is set by the back-end step, which picks the
// arrow, decodes it and updates the position and remaining counters together,
// since each request depends on the state the previous one left. The front end
// classifies rows (direction check, highest-arrow search) into a two-entry
// command queue, so o_ready drops only when that queue is full behind a stalled
// output. Length registers take effect for the next first-arrow request.
module banded_alignment_traceback_step_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bats_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output bats_pkg::t_out                    o_data,
    input  logic                              i_cfg_we,
    input  logic [bats_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [bats_pkg::LEN_BITS-1:0]     i_cfg_data
);
    import bats_pkg::*;

    logic [LEN_BITS-1:0] r_len_a;
    logic [LEN_BITS-1:0] r_len_b;
    t_cmd                front_cmd;
    t_cmd                q_cmd;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEN_A: r_len_a <= i_cfg_data;
                CFG_LEN_B: r_len_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !q_full;
    assign push    = i_valid && !q_full;

    bats_front u_front (
        .i_req (i_data),
        .o_cmd (front_cmd)
    );

    bats_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    bats_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_len_a     (r_len_a),
        .i_len_b     (r_len_b),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out_data  (o_data)
    );

endmodule

`default_nettype wire

// File: rtl/bats_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bats_front (
    input  bats_pkg::t_in  i_req,
    output bats_pkg::t_cmd o_cmd
);
    import bats_pkg::*;

    logic [ROW_BITS-1:0] row;
    logic [PE_COUNT-1:0] nz;
    logic [1:0]          hi_raw;
    logic [POS_BITS-1:0] hi_pos;
    logic                many;
    t_func               func;

    assign row  = i_req.row_bits[ROW_BITS-1:0];
    assign func = t_func'(i_req.func);

    // highest nonzero pair; more than one set bit in nz means several arrows
    always_comb begin
        hi_raw = ARW_ZERO;
        hi_pos = '0;
        for (int k = 0; k < PE_COUNT; k++) begin
            nz[k] = (row[2*k +: 2] != ARW_ZERO);
            if (nz[k]) begin
                hi_raw = row[2*k +: 2];
                hi_pos = POS_BITS'(2 * k);
            end
        end
    end

    assign many = ((nz & (nz - PE_COUNT'(1))) != '0);

    always_comb begin
        o_cmd      = '0;
        o_cmd.func = func;
        o_cmd.row  = row;
        o_cmd.raw  = hi_raw;
        o_cmd.pos  = hi_pos;
        o_cmd.dir  = DIR_UNKNOWN;
        o_cmd.stat = ST_OK;
        unique case (func) inside
            FN_DIR: begin
                if (row == PAIRS_V[ROW_BITS-1:0]) begin
                    o_cmd.dir = DIR_V;
                end else if (row == PAIRS_H[ROW_BITS-1:0]) begin
                    o_cmd.dir = DIR_H;
                end else begin
                    o_cmd.stat = ST_BADDIR;
                end
            end
            FN_FIRST: begin
                if (nz == '0) begin
                    o_cmd.stat = ST_NONE;
                end else if (many) begin
                    o_cmd.stat = ST_MANY;
                end
            end
            FN_NEXT, FN_NONE: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bats_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bats_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bats_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output bats_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import bats_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `BATS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QCNT_BITS'(QUEUE_DEPTH), "queue overfilled")
    `BATS_ASSERT_NOW(a_no_pop_empty, r_count == '0, !i_pop, "pop from empty queue")
    `BATS_ASSERT_NEXT(a_ptr_gap, 1'b1, QPTR_BITS'(r_wr_ptr - r_rd_ptr) == QPTR_BITS'(r_count),
                      "queue pointers disagree with count")

endmodule

`default_nettype wire

// File: rtl/bats_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bats_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  bats_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic [bats_pkg::LEN_BITS-1:0] i_len_a,
    input  logic [bats_pkg::LEN_BITS-1:0] i_len_b,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bats_pkg::t_out                o_out_data
);
    import bats_pkg::*;

    t_dir                  r_dir, n_dir;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [2:0]            r_off, n_off;
    logic [1:0]            r_step, n_step;
    logic [INDEX_BITS-1:0] r_rem_a, n_rem_a;
    logic [INDEX_BITS-1:0] r_rem_b, n_rem_b;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                  w_take;
    logic [POS_BITS+1:0]   npos;
    logic                  in_range;
    logic [ROW_BITS-1:0]   shifted;
    logic [INDEX_BITS-1:0] tk_ra, tk_rb, tk_na, tk_nb;
    logic [1:0]            tk_raw, tk_a;
    t_status               tk_stat_in, tk_stat;
    logic                  tk_both0, tk_forced, tk_ga, tk_gb, use_a, use_b;
    logic [1:0]            dc_step;
    logic [2:0]            dc_off;
    t_dir                  dc_dir;
    logic                  do_take;
    t_out                  res;

    assign w_take    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_take;

    // position of the next arrow, range checked against the row
    assign npos     = {2'b00, r_pos} + {{(POS_BITS-1){r_off[2]}}, r_off};
    assign in_range = !npos[POS_BITS+1] && (npos < (POS_BITS+2)'(ROW_BITS));
    assign shifted  = i_cmd.row >> npos[POS_BITS-1:0];

    always_comb begin
        if (i_cmd.func == FN_FIRST) begin
            tk_ra      = INDEX_BITS'(i_len_a);
            tk_rb      = INDEX_BITS'(i_len_b);
            tk_raw     = i_cmd.raw;
            tk_stat_in = i_cmd.stat;
        end else begin
            tk_ra      = r_rem_a;
            tk_rb      = r_rem_b;
            tk_raw     = shifted[1:0];
            tk_stat_in = ST_OK;
        end
        tk_both0  = (tk_ra == '0) && (tk_rb == '0);
        tk_forced = (tk_ra == '0) || (tk_rb == '0);
        // an exhausted sequence forces the arrow
        if (tk_ra == '0) begin
            tk_a = ARW_LEFT;
        end else if (tk_rb == '0) begin
            tk_a = ARW_UP;
        end else begin
            tk_a = tk_raw;
        end
        tk_stat = tk_stat_in;
        if (tk_stat == ST_OK && r_dir == DIR_UNKNOWN) begin
            tk_stat = ST_BADDIR;
        end
        if (tk_stat == ST_OK && !tk_forced && tk_a == ARW_ZERO) begin
            tk_stat = ST_ZERO;
        end
        use_a = (tk_a != ARW_LEFT);
        use_b = (tk_a != ARW_UP);
        tk_ga = !use_a || (tk_ra == '0);
        tk_gb = !use_b || (tk_rb == '0);
        tk_na = tk_ga ? tk_ra : tk_ra - INDEX_BITS'(1);
        tk_nb = tk_gb ? tk_rb : tk_rb - INDEX_BITS'(1);
    end

    // arrow decode against the band direction
    always_comb begin
        dc_step = 2'd0;
        dc_off  = OFF_ZERO;
        dc_dir  = r_dir;
        case (r_dir)
            DIR_V: begin
                case (tk_a)
                    ARW_UP:   begin dc_step = 2'd1; dc_dir = DIR_H; end
                    ARW_LEFT: begin dc_step = 2'd1; dc_off = OFF_PLUS2; dc_dir = DIR_H; end
                    ARW_DIAG: dc_step = 2'd2;
                    default: ;
                endcase
            end
            DIR_H: begin
                case (tk_a)
                    ARW_UP:   begin dc_step = 2'd1; dc_off = OFF_MINUS2; dc_dir = DIR_V; end
                    ARW_LEFT: begin dc_step = 2'd1; dc_dir = DIR_V; end
                    ARW_DIAG: dc_step = 2'd2;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_dir   = r_dir;
        n_pos   = r_pos;
        n_off   = r_off;
        n_step  = r_step;
        n_rem_a = r_rem_a;
        n_rem_b = r_rem_b;
        res     = '0;
        do_take = 1'b0;
        if (w_take) begin
            unique case (i_cmd.func)
                FN_DIR: begin
                    n_dir         = i_cmd.dir;
                    n_step        = 2'd1;
                    res.status    = i_cmd.stat;
                    res.rows_back = 2'd1;
                end
                FN_FIRST: begin
                    n_pos   = i_cmd.pos;
                    n_rem_a = tk_ra;
                    n_rem_b = tk_rb;
                    if (tk_both0) begin
                        n_step       = 2'd0;
                        res.done_res = 1'b1;
                    end else begin
                        do_take = 1'b1;
                    end
                end
                FN_NEXT: begin
                    if (tk_both0) begin
                        n_step       = 2'd0;
                        res.done_res = 1'b1;
                    end else if (!in_range) begin
                        res.status    = ST_OUT;
                        res.rows_back = r_step;
                    end else begin
                        n_pos   = npos[POS_BITS-1:0];
                        do_take = 1'b1;
                    end
                end
                FN_NONE: begin
                end
            endcase
        end
        if (do_take) begin
            n_dir          = dc_dir;
            n_step         = dc_step;
            n_off          = dc_off;
            n_rem_a        = tk_na;
            n_rem_b        = tk_nb;
            res.status     = tk_stat;
            res.step_valid = 1'b1;
            res.gap_a      = tk_ga;
            res.gap_b      = tk_gb;
            res.index_a    = tk_ga ? '0 : LEN_BITS'(tk_na);
            res.index_b    = tk_gb ? '0 : LEN_BITS'(tk_nb);
            res.arrow_used = tk_a;
            res.rows_back  = dc_step;
            res.done_res   = (tk_na == '0) && (tk_nb == '0);
        end
        n_out_valid = w_take ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        n_out       = w_take ? res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_UNKNOWN;
            r_pos       <= '0;
            r_off       <= OFF_ZERO;
            r_step      <= 2'd0;
            r_rem_a     <= '0;
            r_rem_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dir       <= n_dir;
            r_pos       <= n_pos;
            r_off       <= n_off;
            r_step      <= n_step;
            r_rem_a     <= n_rem_a;
            r_rem_b     <= n_rem_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BATS_ASSERT_NEXT(a_done_empties, w_take && res.done_res,
                      r_rem_a == '0 && r_rem_b == '0, "done reported with symbols left")
    `BATS_ASSERT_NOW(a_no_column_clear, r_out_valid && !r_out.step_valid,
                     !r_out.gap_a && !r_out.gap_b && r_out.index_a == '0 &&
                     r_out.index_b == '0 && r_out.arrow_used == ARW_ZERO,
                     "column fields set without a column")
    `BATS_ASSERT_NOW(a_offset_legal, 1'b1,
                     r_off == OFF_ZERO || r_off == OFF_PLUS2 || r_off == OFF_MINUS2,
                     "illegal position offset")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bats_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAUSE = 4;
    localparam int ITEMS_PER_PHASE = 50;

    localparam t_out RES_NONE = '0;
    localparam t_out RES_DONE =
        '{ST_OK, 1'b0, 1'b0, 1'b0, 24'd0, 24'd0, ARW_ZERO, 2'd0, 1'b1};
    localparam t_out RES_DIR_OK =
        '{ST_OK, 1'b0, 1'b0, 1'b0, 24'd0, 24'd0, ARW_ZERO, 2'd1, 1'b0};
    localparam t_out RES_DIR_BAD =
        '{ST_BADDIR, 1'b0, 1'b0, 1'b0, 24'd0, 24'd0, ARW_ZERO, 2'd1, 1'b0};

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_BITS-1:0] cfg_idx;
        logic [LEN_BITS-1:0]     cfg_val;
        t_in                     req;
        logic                    fixed;
        t_out                    res;
    } t_plan_row;

    typedef struct packed {
        logic fixed;
        t_out res;
    } t_typed;

    // fixed=1 rows carry a hand-written result; the rest go through the predictor
    localparam t_plan_row PLAN [0:29] = '{
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'd0}, 1'b1, RES_DONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'd0}, 1'b1, RES_DONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_DIR, 64'd0}, 1'b1, RES_DIR_BAD},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_DIR, PAIRS_V}, 1'b1, RES_DIR_OK},
        '{1'b1, CFG_LEN_A, 24'hFFFFFF, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b1, CFG_LEN_B, 24'd3, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'hC000_0000_0000_0004}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'h8000_0000_0000_0000}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_DIR, PAIRS_H}, 1'b1, RES_DIR_OK},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'h1}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_DIR, 64'h5555_5555_5555_5554}, 1'b1, RES_DIR_BAD},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'h0C00}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_DIR, PAIRS_V}, 1'b1, RES_DIR_OK},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'h0020}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'd0}, 1'b0, RES_NONE},
        '{1'b1, CFG_LEN_A, 24'd0, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b1, CFG_LEN_B, 24'd2, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, RES_DONE},
        '{1'b1, CFG_LEN_A, 24'd2, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b1, CFG_LEN_B, 24'd0, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'h3}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_NEXT, PAIRS_V}, 1'b0, RES_NONE},
        '{1'b1, CFG_LEN_B, 24'hFFFFFF, '{FN_NONE, 64'd0}, 1'b0, RES_NONE},
        '{1'b0, CFG_LEN_A, 24'd0, '{FN_FIRST, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, RES_NONE}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    t_in                     i_data = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    t_out                    o_data;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [LEN_BITS-1:0]     i_cfg_data = '0;

    // predictor state
    logic [LEN_BITS-1:0]   len_a = '0;
    logic [LEN_BITS-1:0]   len_b = '0;
    t_dir                  band_dir = DIR_UNKNOWN;
    logic [POS_BITS-1:0]   arrow_pos = '0;
    logic [2:0]            pos_offset = OFF_ZERO;
    logic [1:0]            row_step = 2'd0;
    logic [INDEX_BITS-1:0] rem_a = '0;
    logic [INDEX_BITS-1:0] rem_b = '0;
    logic [1:0]            last_arrow = ARW_ZERO;

    t_out   expected_columns [$];
    t_typed typed_columns [$];
    t_typed typed;
    t_out   column;
    int     failures = 0;
    int     stall_cycles = 0;
    int     items_sent = 0;
    int     tx_idle_pct = 24;
    int     rx_idle_pct = 64;

    banded_alignment_traceback_step_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Force at a sequence end, decode by band direction; a column or a done result.
    function automatic t_out take_column(input logic [1:0] raw, input t_status st_in);
        t_out       res;
        logic [1:0] arw;
        logic       forced;
        t_status    st;
        res = '0;
        arw = raw;
        forced = 1'b0;
        st = st_in;
        if (rem_a == 0 && rem_b == 0) begin
            res.done_res = 1'b1;
            row_step = 2'd0;
            return res;
        end
        if (rem_a == 0) begin
            arw = ARW_LEFT;
            forced = 1'b1;
        end else if (rem_b == 0) begin
            arw = ARW_UP;
            forced = 1'b1;
        end
        if (st == ST_OK && band_dir == DIR_UNKNOWN) st = ST_BADDIR;
        if (st == ST_OK && !forced && arw == ARW_ZERO) st = ST_ZERO;
        last_arrow = arw;

        row_step = 2'd0;
        pos_offset = OFF_ZERO;
        case (band_dir)
            DIR_V: begin
                case (arw)
                    ARW_UP: begin
                        row_step = 2'd1;
                        band_dir = DIR_H;
                    end
                    ARW_LEFT: begin
                        row_step = 2'd1;
                        pos_offset = OFF_PLUS2;
                        band_dir = DIR_H;
                    end
                    ARW_DIAG: row_step = 2'd2;
                    default: ;
                endcase
            end
            DIR_H: begin
                case (arw)
                    ARW_UP: begin
                        row_step = 2'd1;
                        pos_offset = OFF_MINUS2;
                        band_dir = DIR_V;
                    end
                    ARW_LEFT: begin
                        row_step = 2'd1;
                        band_dir = DIR_V;
                    end
                    ARW_DIAG: row_step = 2'd2;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (arw != ARW_LEFT && rem_a != 0) begin
            rem_a = rem_a - 1'b1;
            res.index_a = rem_a;
        end else begin
            res.gap_a = 1'b1;
        end
        if (arw != ARW_UP && rem_b != 0) begin
            rem_b = rem_b - 1'b1;
            res.index_b = rem_b;
        end else begin
            res.gap_b = 1'b1;
        end

        res.status = st;
        res.step_valid = 1'b1;
        res.arrow_used = arw;
        res.rows_back = row_step;
        res.done_res = (rem_a == 0 && rem_b == 0);
        return res;
    endfunction

    function automatic t_out trace_step(input t_in req);
        t_out                res;
        int unsigned         hits;
        logic [1:0]          raw;
        logic [POS_BITS-1:0] pos;
        int                  npos;
        t_status             st;
        res = '0;
        case (req.func)
            FN_DIR: begin
                if (req.row_bits == PAIRS_V) begin
                    band_dir = DIR_V;
                end else if (req.row_bits == PAIRS_H) begin
                    band_dir = DIR_H;
                end else begin
                    band_dir = DIR_UNKNOWN;
                    res.status = ST_BADDIR;
                end
                row_step = 2'd1;
                res.rows_back = 2'd1;
            end
            FN_FIRST: begin
                hits = 0;
                raw = ARW_ZERO;
                pos = '0;
                // highest nonzero pair wins
                for (int k = 0; k < PE_COUNT; k++) begin
                    if (req.row_bits[2*k +: 2] != 2'b00) begin
                        hits++;
                        raw = req.row_bits[2*k +: 2];
                        pos = POS_BITS'(2 * k);
                    end
                end
                if (hits == 0) st = ST_NONE;
                else if (hits > 1) st = ST_MANY;
                else st = ST_OK;
                rem_a = len_a;
                rem_b = len_b;
                arrow_pos = pos;
                res = take_column(raw, st);
            end
            FN_NEXT: begin
                if (rem_a == 0 && rem_b == 0) begin
                    row_step = 2'd0;
                    res.done_res = 1'b1;
                end else begin
                    npos = int'(arrow_pos) + int'($signed(pos_offset));
                    if (npos < 0 || npos >= 2 * PE_COUNT) begin
                        // state held, row step reported again
                        res.status = ST_OUT;
                        res.rows_back = row_step;
                    end else begin
                        arrow_pos = POS_BITS'(npos);
                        res = take_column(req.row_bits[arrow_pos +: 2], ST_OK);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_failure(input string what, input t_out exp, input t_out got);
        failures++;
        if (failures <= 10) begin
            $write("%0t %s: exp st=%0d v=%0d ga=%0d gb=%0d ia=%h ib=%h arw=%0d rb=%0d dn=%0d",
                   $realtime, what,
                   exp.status, exp.step_valid, exp.gap_a, exp.gap_b, exp.index_a,
                   exp.index_b, exp.arrow_used, exp.rows_back, exp.done_res);
            $display(" | got st=%0d v=%0d ga=%0d gb=%0d ia=%h ib=%h arw=%0d rb=%0d dn=%0d",
                     got.status, got.step_valid, got.gap_a, got.gap_b, got.index_a,
                     got.index_b, got.arrow_used, got.rows_back, got.done_res);
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_cycles++;
            if (i_valid && o_ready) begin
                typed = typed_columns.pop_front();
                column = trace_step(i_data);
                expected_columns.push_back(typed.fixed ? typed.res : column);
                stall_cycles = 0;
            end
            if (o_valid && i_ready) begin
                stall_cycles = 0;
                if (expected_columns.size() == 0) begin
                    report_failure("unexpected result", RES_NONE, o_data);
                end else begin
                    column = expected_columns.pop_front();
                    if (o_data.status !== column.status ||
                        o_data.step_valid !== column.step_valid ||
                        o_data.gap_a !== column.gap_a ||
                        o_data.gap_b !== column.gap_b ||
                        o_data.index_a !== column.index_a ||
                        o_data.index_b !== column.index_b ||
                        o_data.arrow_used !== column.arrow_used ||
                        o_data.rows_back !== column.rows_back ||
                        o_data.done_res !== column.done_res)
                        report_failure("mismatch", column, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_req(input t_in req, input logic fixed, input t_out res);
        typed_columns.push_back(t_typed'{fixed, res});
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (req.func != FN_NONE) items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_columns.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [LEN_BITS-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LEN_A) len_a = value;
        else len_b = value;
    endtask

    function automatic logic [LEN_BITS-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2: return LEN_BITS'($urandom());
            default: return LEN_BITS'($urandom_range(1, 24));
        endcase
    endfunction

    // direction row, first arrow row, then a run of next-row requests
    task automatic run_traceback();
        t_in         req;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        req.func = FN_DIR;
        if (pick < 8) req.row_bits = $urandom_range(0, 1) ? PAIRS_V : PAIRS_H;
        else if (pick == 8) req.row_bits = PAIRS_V ^ (64'd1 << $urandom_range(0, 63));
        else req.row_bits = {$urandom(), $urandom()};
        send_req(req, 1'b0, RES_NONE);

        pick = $urandom_range(0, 9);
        req.func = FN_FIRST;
        if (pick < 7)
            req.row_bits = 64'($urandom_range(1, 3)) << (2 * $urandom_range(0, PE_COUNT - 1));
        else if (pick == 7) req.row_bits = '0;
        else req.row_bits = {$urandom(), $urandom()};
        send_req(req, 1'b0, RES_NONE);

        repeat ($urandom_range(1, 32)) begin
            req.func = FN_NEXT;
            req.row_bits = {$urandom(), $urandom()};
            send_req(req, 1'b0, RES_NONE);
        end
    endtask

    initial begin
        t_in req;
        int  goal;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[i]) begin
            if (PLAN[i].is_cfg) set_length(PLAN[i].cfg_idx, PLAN[i].cfg_val);
            else send_req(PLAN[i].req, PLAN[i].fixed, PLAN[i].res);
        end

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 64 : 0;
            rx_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 24 : 0;
            for (int phase = 0; phase < 6; phase++) begin
                set_length(CFG_LEN_A, pick_length());
                set_length(CFG_LEN_B, pick_length());
                goal = items_sent + ITEMS_PER_PHASE;
                while (items_sent < goal) begin
                    if ($urandom_range(0, 9) != 0) begin
                        run_traceback();
                    end else begin
                        repeat ($urandom_range(1, 3)) begin
                            req.func = 2'($urandom_range(0, 3));
                            req.row_bits = {$urandom(), $urandom()};
                            send_req(req, 1'b0, RES_NONE);
                        end
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
